@@ hw/rtl/utility_transaction_parser_twu_top_defines.svh @@
// Assertion macros for the transaction parser
`ifndef UTILITY_TRANSACTION_PARSER_TWU_TOP_DEFINES_SVH
`define UTILITY_TRANSACTION_PARSER_TWU_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define TWU_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("twu assertion failed");
`define TWU_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("twu forbidden condition");
`else
`define TWU_ASSERT(lbl, clk, rst_n, prop)
`define TWU_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

@@ hw/rtl/twu_pkg.sv @@
// Shared types and constants of the transaction parser
package twu_pkg;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] SEP_RESET = 8'h20;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_MISMATCH = 3'd1;
  localparam logic [2:0] ST_BADNUM   = 3'd2;
  localparam logic [2:0] ST_RANGE    = 3'd3;
  localparam logic [2:0] ST_TOOMANY  = 3'd4;

  localparam logic [1:0] MODE_ITEMS = 2'd0;
  localparam logic [1:0] MODE_TOTAL = 2'd1;
  localparam logic [1:0] MODE_UTILS = 2'd2;

  localparam logic KIND_TXN  = 1'b0;
  localparam logic KIND_READ = 1'b1;
  localparam logic OP_BYTE   = 1'b0;

  localparam logic [31:0] OVF_LIMIT = 32'd429496729;

  typedef struct packed {
    logic byte_go;
    logic rd_go;
    logic rd_load;
    logic clr_step;
    logic cm_buf_rd;
    logic cm_tab_rd;
    logic cm_wr;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic commit;
    logic walk_last;
    logic out_full;
  } stat_t;
endpackage

@@ hw/rtl/twu_ram.sv @@
// Generic single-write, single-read RAM with registered read data
module twu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                               clk,
  input  logic                               we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                   wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                   rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

@@ hw/rtl/twu_ctrl.sv @@
// Controller state machine: clear sweep, reads, line-end table walk
`include "utility_transaction_parser_twu_top_defines.svh"
module twu_ctrl
  import twu_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_tvalid,
  input  logic  in_opcode,
  input  logic  out_tready,
  input  stat_t stat,
  output logic  in_tready,
  output cmd_t  cmd
);
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_RD    = 3'd2;
  localparam logic [2:0] S_CB    = 3'd3;
  localparam logic [2:0] S_CT    = 3'd4;
  localparam logic [2:0] S_CW    = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       acc;

  assign in_tready = (state_r == S_IDLE) && (!stat.out_full || out_tready);
  assign acc = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (acc) begin
          if (in_opcode == OP_BYTE) begin
            cmd.byte_go = 1'b1;
            if (stat.commit) state_nxt = S_CB;
          end else begin
            cmd.rd_go = 1'b1;
            state_nxt = S_RD;
          end
        end
      end
      S_RD: begin
        cmd.rd_load = 1'b1;
        state_nxt = S_IDLE;
      end
      S_CB: begin
        cmd.cm_buf_rd = 1'b1;
        state_nxt = S_CT;
      end
      S_CT: begin
        cmd.cm_tab_rd = 1'b1;
        state_nxt = S_CW;
      end
      S_CW: begin
        cmd.cm_wr = 1'b1;
        state_nxt = stat.walk_last ? S_IDLE : S_CB;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  `TWU_ASSERT(a_rd_one_cycle, clk, rst_n, (state_r == S_RD) |=> (state_r == S_IDLE))
  `TWU_ASSERT(a_walk_loops, clk, rst_n,
    (state_r == S_CW && !stat.walk_last) |=> (state_r == S_CB))
endmodule

@@ hw/rtl/twu_dp.sv @@
// Datapath: byte parser, item buffer, TWU table and result register
`include "utility_transaction_parser_twu_top_defines.svh"
module twu_dp
  import twu_pkg::*;
#(
  parameter int TWU_ENTRIES = 4096,
  parameter int MAX_ITEMS   = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output stat_t       stat,
  input  logic [7:0]  data_byte,
  input  logic        last_in_buffer,
  input  logic [11:0] read_index,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  input  logic        out_tready,
  output logic        out_valid,
  output logic        out_kind,
  output logic [2:0]  out_status,
  output logic [6:0]  out_count,
  output logic [31:0] out_total,
  output logic [31:0] out_twu
);
  localparam int AW = TWU_ENTRIES > 1 ? $clog2(TWU_ENTRIES) : 1;
  localparam int BW = MAX_ITEMS > 1 ? $clog2(MAX_ITEMS) : 1;
  localparam int XW = AW > 12 ? AW : 12;
  localparam logic [6:0] MAX_CNT = 7'(MAX_ITEMS);
  localparam logic [6:0] UTIL_SAT = 7'(MAX_ITEMS + 1);

  logic [7:0]  sep_r;
  logic        halted_r, halted_nxt;
  logic [1:0]  mode_r, mode_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic        open_r, open_nxt, dig_r, dig_nxt, bad_r, bad_nxt;
  logic [31:0] held_r, held_nxt;
  logic [6:0]  items_r, items_nxt, utils_r, utils_nxt;
  logic [AW-1:0] clr_cnt_r;
  logic [6:0]  cm_idx_r, cm_count_r;
  logic [31:0] cm_total_r;
  logic [AW-1:0] cm_id_r;
  logic        rd_ok_r;
  logic        ov_r, okind_r;
  logic [2:0]  ostat_r;
  logic [6:0]  ocnt_r;
  logic [31:0] otot_r, otwu_r;

  logic        res_load, commit, buf_we;
  logic [2:0]  res_status;
  logic [6:0]  res_count;
  logic [31:0] res_total;
  logic [AW-1:0] buf_wdata;

  logic [AW-1:0] buf_rdata, tab_raddr, tab_waddr;
  logic [31:0]   tab_rdata, tab_wdata;
  logic          tab_we;
  logic [XW-1:0] rd_ext;

  // byte parser
  always_comb begin
    logic delim, digit, do_close, colon, fin, cbad, dg, err;
    logic [31:0] d, cv, ten;
    logic [2:0] ecode;
    delim = (data_byte == sep_r) || (data_byte == CH_COLON) || (data_byte == CH_NL);
    digit = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
    d = digit ? 32'(data_byte - CH_ZERO) : 32'd0;
    ten = {acc_r[28:0], 3'b000} + {acc_r[30:0], 1'b0};
    mode_nxt = mode_r; acc_nxt = acc_r; held_nxt = held_r;
    open_nxt = open_r; dig_nxt = dig_r; bad_nxt = bad_r;
    items_nxt = items_r; utils_nxt = utils_r; halted_nxt = halted_r;
    res_load = 1'b0; res_status = ST_OK; res_count = items_r; res_total = held_r;
    commit = 1'b0; buf_we = 1'b0;
    do_close = 1'b0; colon = 1'b0; fin = 1'b0;
    cv = acc_r; cbad = bad_r; dg = dig_r; err = 1'b0; ecode = ST_OK;
    if (!halted_r) begin
      if (delim) begin
        do_close = open_r;
        colon = (data_byte == CH_COLON);
        fin = (data_byte == CH_NL);
      end else begin
        if (!open_r) begin
          cv = d; cbad = !digit; dg = digit;
        end else if (dig_r) begin
          if (!digit) begin
            dg = 1'b0;
          end else if (acc_r > OVF_LIMIT || (acc_r == OVF_LIMIT && d > 32'd5)) begin
            dg = 1'b0; cbad = 1'b1;
          end else begin
            cv = ten + d;
          end
        end
        acc_nxt = cv; open_nxt = 1'b1; dig_nxt = dg; bad_nxt = cbad;
        do_close = last_in_buffer;
        fin = 1'b1;
      end
      if (do_close) begin
        open_nxt = 1'b0; dig_nxt = 1'b0; bad_nxt = 1'b0; acc_nxt = '0;
        if (cbad) begin
          err = 1'b1; ecode = ST_BADNUM;
        end else begin
          case (mode_r)
            MODE_ITEMS: begin
              if (cv >= 32'(TWU_ENTRIES)) begin
                err = 1'b1; ecode = ST_RANGE;
              end else if (items_r >= MAX_CNT) begin
                err = 1'b1; ecode = ST_TOOMANY;
              end else begin
                buf_we = 1'b1;
                items_nxt = items_r + 7'd1;
                if (colon) mode_nxt = MODE_TOTAL;
              end
            end
            MODE_TOTAL: begin
              held_nxt = cv;
              mode_nxt = MODE_UTILS;
            end
            default: begin
              if (utils_r < UTIL_SAT) utils_nxt = utils_r + 7'd1;
            end
          endcase
        end
        if (err) begin
          res_load = 1'b1; res_status = ecode; halted_nxt = 1'b1;
        end else if (fin) begin
          res_load = 1'b1; res_count = items_nxt; res_total = held_nxt;
          if (items_nxt != utils_nxt) begin
            res_status = ST_MISMATCH; halted_nxt = 1'b1;
          end else begin
            commit = 1'b1;
            mode_nxt = MODE_ITEMS; items_nxt = '0; utils_nxt = '0;
          end
        end
      end
      if (last_in_buffer) begin
        mode_nxt = MODE_ITEMS; acc_nxt = '0; held_nxt = '0;
        open_nxt = 1'b0; dig_nxt = 1'b0; bad_nxt = 1'b0;
        items_nxt = '0; utils_nxt = '0;
      end
    end
    buf_wdata = cv[AW-1:0];
  end

  assign rd_ext = XW'(read_index);
  assign tab_raddr = cmd.rd_go ? AW'(rd_ext) : buf_rdata;
  assign tab_we = cmd.clr_step || cmd.cm_wr;
  assign tab_waddr = cmd.clr_step ? clr_cnt_r : cm_id_r;
  assign tab_wdata = cmd.clr_step ? 32'd0 : tab_rdata + cm_total_r;

  twu_ram #(.WIDTH(AW), .DEPTH(MAX_ITEMS)) u_buf (
    .clk(clk), .we(buf_we && cmd.byte_go), .waddr(items_r[BW-1:0]), .wdata(buf_wdata),
    .raddr(cm_idx_r[BW-1:0]), .rdata(buf_rdata)
  );

  twu_ram #(.WIDTH(32), .DEPTH(TWU_ENTRIES)) u_tab (
    .clk(clk), .we(tab_we), .waddr(tab_waddr), .wdata(tab_wdata),
    .raddr(tab_raddr), .rdata(tab_rdata)
  );

  assign stat.clr_last = (clr_cnt_r == AW'(TWU_ENTRIES - 1));
  assign stat.commit = commit;
  assign stat.walk_last = ((cm_idx_r + 7'd1) == cm_count_r);
  assign stat.out_full = ov_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sep_r <= SEP_RESET; halted_r <= 1'b0; mode_r <= MODE_ITEMS;
      acc_r <= '0; open_r <= 1'b0; dig_r <= 1'b0; bad_r <= 1'b0;
      held_r <= '0; items_r <= '0; utils_r <= '0;
      clr_cnt_r <= '0; cm_idx_r <= '0; ov_r <= 1'b0;
    end else begin
      if (cfg_we) sep_r <= cfg_wdata;
      if (cmd.clr_step) clr_cnt_r <= clr_cnt_r + AW'(1);
      if (cmd.byte_go) begin
        halted_r <= halted_nxt; mode_r <= mode_nxt; acc_r <= acc_nxt;
        open_r <= open_nxt; dig_r <= dig_nxt; bad_r <= bad_nxt;
        held_r <= held_nxt; items_r <= items_nxt; utils_r <= utils_nxt;
      end
      if (cmd.byte_go && commit) cm_idx_r <= '0;
      else if (cmd.cm_wr) cm_idx_r <= cm_idx_r + 7'd1;
      if (cmd.rd_load || (cmd.byte_go && res_load)) ov_r <= 1'b1;
      else if (out_tready) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.byte_go && commit) begin
      cm_count_r <= res_count;
      cm_total_r <= res_total;
    end
    if (cmd.cm_tab_rd) cm_id_r <= buf_rdata;
    if (cmd.rd_go) rd_ok_r <= ({20'd0, read_index} < 32'(TWU_ENTRIES));
    if (cmd.byte_go && res_load) begin
      okind_r <= KIND_TXN; ostat_r <= res_status; ocnt_r <= res_count;
      otot_r <= res_total; otwu_r <= '0;
    end else if (cmd.rd_load) begin
      okind_r <= KIND_READ; ostat_r <= ST_OK; ocnt_r <= '0;
      otot_r <= '0; otwu_r <= rd_ok_r ? tab_rdata : 32'd0;
    end
  end

  assign out_valid = ov_r;
  assign out_kind = okind_r;
  assign out_status = ostat_r;
  assign out_count = ocnt_r;
  assign out_total = otot_r;
  assign out_twu = otwu_r;

  `TWU_NEVER(a_no_overwrite, clk, rst_n,
    (cmd.rd_load || (cmd.byte_go && res_load)) && ov_r && !out_tready)
  `TWU_NEVER(a_walk_bound, clk, rst_n, cmd.cm_wr && (cm_idx_r >= cm_count_r))
endmodule

@@ hw/rtl/utility_transaction_parser_twu_top.sv @@
// Transaction-weighted utility parser, top level
// Input stream: one transfer per text byte (in_tuser = 0) or per table read
// (in_tuser = 1). in_tlast marks the last byte of a buffer.
// Result stream: one transfer per finished line, per error, and per read.
// The user must write the separator byte through cfg_we/cfg_wdata while
// idle; the block itself does not enforce it. After reset the block
// sweeps the TWU table to zero, one entry per cycle, with in_tready low.
// A stream byte is parsed as it is taken; a read passes through S_RD, where
// the table RAM read data is loaded into the output register. A line that
// commits walks its items: item buffer read, table read, table write.
// The result sits in an output register; a new transfer is taken while it
// is pending only if out_tready frees the register in that cycle.
// After an error the parser halts: bytes are taken and dropped, reads work.
module utility_transaction_parser_twu_top
  import twu_pkg::*;
#(
  parameter int TWU_ENTRIES = 4096,
  parameter int MAX_ITEMS   = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // data_byte[7:0], read_index[19:8]
  input  logic        in_tuser,   // opcode
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // status[2:0], item_count[9:3],
                                  // txn_total[41:10], twu_value[73:42]
  output logic        out_tuser,  // kind
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata
);
  cmd_t        cmd;
  stat_t       stat;
  logic [2:0]  o_status;
  logic [6:0]  o_count;
  logic [31:0] o_total, o_twu;

  twu_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_opcode(in_tuser),
    .out_tready(out_tready), .stat(stat), .in_tready(in_tready), .cmd(cmd)
  );

  twu_dp #(.TWU_ENTRIES(TWU_ENTRIES), .MAX_ITEMS(MAX_ITEMS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
    .data_byte(in_tdata[7:0]), .last_in_buffer(in_tlast),
    .read_index(in_tdata[19:8]), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .out_tready(out_tready), .out_valid(out_tvalid), .out_kind(out_tuser),
    .out_status(o_status), .out_count(o_count), .out_total(o_total),
    .out_twu(o_twu)
  );

  assign out_tdata = {6'd0, o_twu, o_total, o_count, o_status};
endmodule
